// File: hdl/sfrd_pkg.sv
// ----------------------------------------------------------------------------
// sfrd_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the serial bus frame receiver and channel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfrd_pkg;

  // frame layout
  localparam int unsigned STORE_DEPTH = 24;
  localparam int unsigned STORE_AW    = 5;
  localparam int unsigned LAST_STORE  = STORE_DEPTH - 1;
  localparam logic [7:0]  SYNC_BYTE   = 8'h0F;
  localparam logic [7:0]  END_BYTE    = 8'h00;
  localparam int unsigned FAILSAFE_BIT = 3;
  localparam int unsigned CHAN_BITS   = 11;
  localparam int unsigned SCALE_SHIFT = 6;

  // channel count limits
  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned MAX_CHANNELS     = 16;

  // configuration registers
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_RESYNC_GAP = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CENTRE     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CHAN_ORDER = 2'd2;

  localparam logic [15:0] RESYNC_GAP_RST = 16'd2500;
  localparam logic [10:0] CENTRE_RST     = 11'd1010;
  localparam logic [63:0] CHAN_ORDER_RST = 64'hFEDC_BA98_7654_3210;

  // controller to datapath commands
  typedef struct packed {
    logic                store_we;
    logic [STORE_AW-1:0] store_addr;
    logic                fs_capture;
    logic [STORE_AW-1:0] rd_addr;
    logic                win_shift;
    logic                load_out;
    logic [3:0]          chan;
    logic [2:0]          bit_sh;
    logic                last;
  } sfrd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_sync;
    logic is_end;
    logic gap_over;
  } sfrd_sts_t;

endpackage

`default_nettype wire

// File: hdl/sbus_frame_receiver_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver_decoder
// Serial bus frame receiver: assembles 25-byte frames from received bytes and
// emits one decoded result per channel when a frame completes.
// ----------------------------------------------------------------------------
// Received bytes are taken whenever the block is idle; a byte that completes a frame with
// a valid end byte then occupies the block while the channels are decoded,
// and in_ready stays low until the last channel item has been taken. Decoding
// runs through the single read port of the 24-byte frame store: every channel
// needs three byte reads, a load into the result registers and a transfer on
// the result port, which can stall on out_ready. Results come out in frame
// channel order. Configuration is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_receiver_decoder #(
  parameter int unsigned NUM_CHANNELS = sfrd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [sfrd_pkg::CFG_AW-1:0] cfg_index,
  input  wire logic [sfrd_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_rx_byte,
  input  wire logic [15:0]                 in_gap_us,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [3:0]                       out_dest_channel,
  output logic [10:0]                      out_raw_value,
  output logic signed [17:0]               out_scaled_value,
  output logic                             out_link_ok,
  output logic                             out_last
);
  import sfrd_pkg::*;

  sfrd_cmd_t cmd;
  sfrd_sts_t sts;

  // sequencer
  sfrd_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sfrd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_rx_byte       (in_rx_byte),
    .in_gap_us        (in_gap_us),
    .cmd              (cmd),
    .sts              (sts),
    .out_dest_channel (out_dest_channel),
    .out_raw_value    (out_raw_value),
    .out_scaled_value (out_scaled_value),
    .out_link_ok      (out_link_ok),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: hdl/sfrd_ram.sv
// ----------------------------------------------------------------------------
// sfrd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/sfrd_ctrl.sv
// ----------------------------------------------------------------------------
// sfrd_ctrl
// Frame byte counter and unpack sequencer: decides where each received byte
// goes and steps the datapath through the channels of a released frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrd_ctrl #(
  parameter int unsigned NUM_CHANNELS = sfrd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sfrd_pkg::sfrd_sts_t sts,
  output sfrd_pkg::sfrd_cmd_t    cmd
);
  import sfrd_pkg::*;

  localparam int unsigned CH_W  = $clog2(NUM_CHANNELS);
  localparam int unsigned BIT_W = $clog2(CHAN_BITS * NUM_CHANNELS);
  localparam logic [CH_W-1:0]  LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [BIT_W-1:0] CH_STEP = BIT_W'(CHAN_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;
  localparam logic [1:0] ST_SEND  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [STORE_AW-1:0] count_r, count_nxt;
  logic [CH_W-1:0]     k_r, k_nxt;
  logic [BIT_W-1:0]    bitpos_r, bitpos_nxt;
  logic [1:0]          phase_r, phase_nxt;

  logic [STORE_AW-1:0] cnt_eff;
  logic [1:0]          rd_off;
  logic                accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign accept    = in_valid && in_ready;

  // a long gap restarts the count before the byte is handled
  assign cnt_eff = sts.gap_over ? '0 : count_r;
  assign rd_off  = (phase_r == 2'd3) ? 2'd2 : phase_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    bitpos_nxt = bitpos_r;
    phase_nxt  = phase_r;

    cmd            = '0;
    cmd.store_addr = cnt_eff;
    cmd.rd_addr    = STORE_AW'(bitpos_r >> 3) + STORE_AW'(1) + STORE_AW'(rd_off);
    cmd.chan       = 4'(k_r);
    cmd.bit_sh     = bitpos_r[2:0];
    cmd.last       = (k_r == LAST_CH);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_eff == '0) begin
            // hunting for the sync byte
            if (sts.is_sync) begin
              cmd.store_we = 1'b1;
              count_nxt    = STORE_AW'(1);
            end else begin
              count_nxt = '0;
            end
          end else if (cnt_eff >= STORE_AW'(STORE_DEPTH)) begin
            // end byte position: release or drop the frame
            count_nxt = '0;
            if (sts.is_end) begin
              state_nxt  = ST_FETCH;
              k_nxt      = '0;
              bitpos_nxt = '0;
              phase_nxt  = '0;
            end
          end else begin
            cmd.store_we   = 1'b1;
            cmd.fs_capture = (cnt_eff == STORE_AW'(LAST_STORE));
            count_nxt      = cnt_eff + STORE_AW'(1);
          end
        end
      end
      ST_FETCH: begin
        // three byte reads per channel, data lands in the next cycle
        cmd.win_shift = (phase_r != 2'd0);
        phase_nxt     = phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          if (k_r == LAST_CH) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt      = k_r + CH_W'(1);
            bitpos_nxt = bitpos_r + CH_STEP;
            phase_nxt  = '0;
            state_nxt  = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      k_r      <= '0;
      bitpos_r <= '0;
      phase_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      bitpos_r <= bitpos_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sfrd_dp.sv
// ----------------------------------------------------------------------------
// sfrd_dp
// Datapath: configuration registers, frame store, unpack window and the
// result registers for one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sfrd_pkg::CFG_AW-1:0]   cfg_index,
  input  wire logic [sfrd_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire logic [7:0]                    in_rx_byte,
  input  wire logic [15:0]                   in_gap_us,
  input  wire sfrd_pkg::sfrd_cmd_t           cmd,
  output sfrd_pkg::sfrd_sts_t                sts,
  output logic [3:0]                         out_dest_channel,
  output logic [10:0]                        out_raw_value,
  output logic signed [17:0]                 out_scaled_value,
  output logic                               out_link_ok,
  output logic                               out_last
);
  import sfrd_pkg::*;

  logic [15:0] resync_gap_r;
  logic [10:0] centre_r;
  logic [63:0] chan_order_r;
  logic        fs_r;
  logic [23:0] win_r;
  logic [7:0]  rd_data;

  logic [10:0]        raw;
  logic signed [11:0] diff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resync_gap_r <= RESYNC_GAP_RST;
      centre_r     <= CENTRE_RST;
      chan_order_r <= CHAN_ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESYNC_GAP: resync_gap_r <= cfg_wdata[15:0];
        REG_CENTRE:     centre_r     <= cfg_wdata[10:0];
        REG_CHAN_ORDER: chan_order_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // byte classification for the controller
  assign sts.is_sync  = (in_rx_byte == SYNC_BYTE);
  assign sts.is_end   = (in_rx_byte == END_BYTE);
  assign sts.gap_over = (in_gap_us > resync_gap_r);

  // frame store for bytes 0 to 23
  sfrd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH),
    .AW    (STORE_AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_we),
    .waddr (cmd.store_addr),
    .wdata (in_rx_byte),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  // failsafe flag kept from the flags byte as it is stored
  always_ff @(posedge clk) begin
    if (cmd.fs_capture) begin
      fs_r <= in_rx_byte[FAILSAFE_BIT];
    end
  end

  // three-byte little-endian unpack window
  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      win_r <= {rd_data, win_r[23:8]};
    end
  end

  assign raw  = 11'(win_r >> cmd.bit_sh);
  assign diff = $signed({1'b0, raw}) - $signed({1'b0, centre_r});

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dest_channel <= chan_order_r[{cmd.chan, 2'b00} +: 4];
      out_raw_value    <= raw;
      out_scaled_value <= {diff, {SCALE_SHIFT{1'b0}}};
      out_link_ok      <= ~fs_r;
      out_last         <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sfrd_checker.sv
// ----------------------------------------------------------------------------
// sfrd_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [3:0]         out_dest_channel,
  input wire logic [10:0]        out_raw_value,
  input wire logic signed [17:0] out_scaled_value,
  input wire logic               out_link_ok,
  input wire logic               out_last
);

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_raw_value) &&
      $stable(out_scaled_value) && $stable(out_dest_channel) &&
      $stable(out_link_ok) && $stable(out_last))
    else $error("result item changed while stalled");

  // no byte is taken while channel items are being delivered
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // the last item of a frame ends the burst
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("results continued after last item");

  // scaled value is a multiple of 64
  a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scaled_value[5:0] == 6'd0)
    else $error("scaled value not aligned");

endmodule

bind sbus_frame_receiver_decoder sfrd_checker u_sfrd_checker (.*);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial bus frame receiver and channel decoder.
// Sends bytes that form good, broken and noisy frames with random gaps.
// A frame model predicts the channel items. Each item taken from the result
// port is checked against the oldest prediction. Both ports idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfrd_pkg::*;

  localparam int unsigned N_CHAN        = NUM_CHANNELS_DEF;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_REPORTS   = 10;

  // one decoded channel item
  typedef struct packed {
    logic [3:0]         dest;
    logic [10:0]        raw;
    logic signed [17:0] scaled;
    logic               link_ok;
    logic               last;
  } chan_result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_index  = '0;
  logic [CFG_DW-1:0]   cfg_wdata  = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [7:0]          in_rx_byte = '0;
  logic [15:0]         in_gap_us  = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [3:0]          out_dest_channel;
  logic [10:0]         out_raw_value;
  logic signed [17:0]  out_scaled_value;
  logic                out_link_ok;
  logic                out_last;

  // frame model state and its copy of the registers
  logic [15:0]  gap_limit  = RESYNC_GAP_RST;
  logic [10:0]  centre     = CENTRE_RST;
  logic [63:0]  chan_order = CHAN_ORDER_RST;
  logic [4:0]   frame_pos  = '0;
  logic [7:0]   frame_bytes [STORE_DEPTH];
  chan_result_t expected_chans [$];

  int unsigned fail_cnt      = 0;
  int unsigned counted_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned cycle_cnt     = 0;
  logic        rcv_hold      = 1'b0;
  event        hold_start;

  sbus_frame_receiver_decoder #(
    .NUM_CHANNELS(N_CHAN)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_gap_us        (in_gap_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dest_channel (out_dest_channel),
    .out_raw_value    (out_raw_value),
    .out_scaled_value (out_scaled_value),
    .out_link_ok      (out_link_ok),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  // advance the frame model by one byte; returns 0 when the byte is ignored
  function automatic bit decode_byte(input logic [7:0] b, input logic [15:0] g);
    logic [175:0] chan_bits;
    chan_result_t r;
    int           diff;
    if (g > gap_limit) frame_pos = '0;
    if (frame_pos == 0) begin
      if (b != SYNC_BYTE) return 1'b0;
    end else if (frame_pos >= STORE_DEPTH) begin
      frame_pos = '0;
      if (b != END_BYTE) return 1'b1;
      for (int i = 0; i < 22; i++) chan_bits[8*i +: 8] = frame_bytes[i+1];
      for (int k = 0; k < N_CHAN; k++) begin
        r.dest    = chan_order[4*k +: 4];
        r.raw     = chan_bits[11*k +: 11];
        diff      = int'(r.raw) - int'(centre);
        r.scaled  = 18'(diff * 64);
        r.link_ok = ~frame_bytes[LAST_STORE][FAILSAFE_BIT];
        r.last    = (k == N_CHAN - 1);
        expected_chans.push_back(r);
      end
      return 1'b1;
    end
    frame_bytes[frame_pos] = b;
    frame_pos = frame_pos + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [15:0] short_gap();
    return 16'($urandom_range(0, gap_limit));
  endfunction

  function automatic logic [15:0] long_gap();
    return (gap_limit == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(gap_limit + 1, 65535));
  endfunction

  // sixteen channel values, some at the ends of the range
  function automatic logic [175:0] random_chans();
    logic [175:0] v;
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 5))
        0: v[11*k +: 11] = '0;
        1: v[11*k +: 11] = '1;
        default: v[11*k +: 11] = 11'($urandom);
      endcase
    end
    return v;
  endfunction

  // offer one byte, hold it until taken, then update the model
  task automatic send_byte(input logic [7:0] b, input logic [15:0] g);
    int unsigned idle_n;
    idle_n = 0;
    while ($urandom_range(0, 99) < send_idle_pct && idle_n < 40) idle_n++;
    if (idle_n != 0) begin
      in_valid <= 1'b0;
      repeat (idle_n) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_gap_us  <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (decode_byte(b, g)) counted_items++;
  endtask

  // drop valid and let every pending channel item drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic configure(input logic [15:0] gap, input logic [10:0] ctr,
                           input logic [63:0] order);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RESYNC_GAP;
    cfg_wdata <= 64'(gap);
    @(posedge clk);
    cfg_index <= REG_CENTRE;
    cfg_wdata <= 64'(ctr);
    @(posedge clk);
    cfg_index <= REG_CHAN_ORDER;
    cfg_wdata <= order;
    @(posedge clk);
    cfg_we     <= 1'b0;
    gap_limit  = gap;
    centre     = ctr;
    chan_order = order;
  endtask

  // sync, 22 channel bytes, flags byte and closing byte
  task automatic send_frame(input logic [175:0] chans, input logic [7:0] flags,
                            input logic [7:0] tail);
    // no gap can restart the count, so walk it back to zero with filler
    if (gap_limit == 16'hFFFF)
      while (frame_pos != 0) send_byte(8'hFF, short_gap());
    send_byte(SYNC_BYTE,
              (frame_pos != 0 || $urandom_range(0, 3) == 0) ? long_gap() : short_gap());
    for (int i = 0; i < 22; i++) send_byte(chans[8*i +: 8], short_gap());
    send_byte(flags, short_gap());
    send_byte(tail, short_gap());
  endtask

  // compare one taken channel item with the oldest prediction
  task automatic check_chan();
    chan_result_t want, got;
    got = {out_dest_channel, out_raw_value, out_scaled_value, out_link_ok, out_last};
    if (expected_chans.size() == 0) begin
      if (fail_cnt < MAX_REPORTS)
        $display("unexpected channel item: dest %0d raw %0d scaled %0d",
                 got.dest, got.raw, got.scaled);
      fail_cnt++;
      return;
    end
    want = expected_chans.pop_front();
    if (got.dest !== want.dest || got.raw !== want.raw || got.scaled !== want.scaled ||
        got.link_ok !== want.link_ok || got.last !== want.last) begin
      if (fail_cnt < MAX_REPORTS)
        $display("channel mismatch: exp dest %0d raw %0d scaled %0d link %0b last %0b",
                 want.dest, want.raw, want.scaled, want.link_ok, want.last,
                 " / got dest %0d raw %0d scaled %0d link %0b last %0b",
                 got.dest, got.raw, got.scaled, got.link_ok, got.last);
      fail_cnt++;
    end
  endtask

  // result side: check each taken item, then choose the next ready level
  always @(posedge clk) begin
    if (out_valid && out_ready) check_chan();
    out_ready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // long receiver hold-off, counted here in cycles
  initial forever begin
    @(hold_start);
    rcv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_hold <= 1'b0;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("== FAIL ==");
    $finish;
  end

  // bytes other than sync are dropped while hunting, then a plain frame decodes
  task automatic test_sync_hunt();
    send_byte(8'h00, 16'd0);
    send_byte(8'hFF, 16'hFFFF);
    send_byte(8'h0E, 16'd10);
    send_byte(8'h8F, 16'd0);
    send_frame('0, 8'h00, END_BYTE);
  endtask

  // full-scale channels against both centre extremes, failsafe set and clear
  task automatic test_value_extremes();
    configure(RESYNC_GAP_RST, 11'd0, CHAN_ORDER_RST);
    send_frame('1, 8'h08, END_BYTE);
    configure(RESYNC_GAP_RST, 11'h7FF, 64'h0123_4567_89AB_CDEF);
    send_frame('0, 8'hF7, END_BYTE);
  endtask

  // a wrong closing byte drops the frame, the next one still decodes
  task automatic test_bad_end();
    send_frame(random_chans(), 8'h00, 8'h01);
    send_frame(random_chans(), 8'h08, 8'h80);
    send_frame(random_chans(), 8'h00, END_BYTE);
  endtask

  // gaps at the limit keep the frame, gaps above it restart the count
  task automatic test_resync_gap();
    configure(16'd100, CENTRE_RST, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(SYNC_BYTE, 16'd0);
    repeat (10) send_byte(8'($urandom), 16'd100);
    send_frame(random_chans(), 8'h00, END_BYTE);
    // long gap on the closing byte drops the frame
    send_byte(SYNC_BYTE, long_gap());
    repeat (23) send_byte(8'($urandom), short_gap());
    send_byte(END_BYTE, long_gap());
    configure(16'd0, CENTRE_RST, 64'd0);
    send_frame(random_chans(), 8'h00, END_BYTE);
    send_byte(SYNC_BYTE, 16'd0);
    send_byte(8'h55, 16'd1);
  endtask

  // mostly good frames with random content, plus broken frames and noise
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
    int unsigned stop_at;
    send_idle_pct = snd_pct;
    rcv_idle_pct  = rcv_pct;
    stop_at = counted_items + n_items;
    while (counted_items < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1: send_frame(random_chans(), 8'($urandom), 8'($urandom_range(1, 255)));
        2, 3: begin
          send_byte(SYNC_BYTE, long_gap());
          repeat ($urandom_range(1, 23)) send_byte(8'($urandom), short_gap());
        end
        4: repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 16'($urandom));
        default: send_frame(random_chans(), 8'($urandom), END_BYTE);
      endcase
    end
  endtask

  // receiver stalls while frames keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    -> hold_start;
    repeat (3) send_frame(random_chans(), 8'($urandom), END_BYTE);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sync_hunt();
    test_value_extremes();
    test_bad_end();
    test_resync_gap();
    configure(RESYNC_GAP_RST, 11'($urandom), {$urandom, $urandom});
    test_random_traffic(30, 31, 65);
    configure(16'hFFFF, 11'($urandom), {$urandom, $urandom});
    test_random_traffic(30, 65, 31);
    configure(16'($urandom_range(500, 5000)), 11'($urandom), {$urandom, $urandom});
    test_random_traffic(30, 0, 0);
    test_backpressure();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfrd_pkg.sv
hdl/sfrd_ram.sv
hdl/sfrd_ctrl.sv
hdl/sfrd_dp.sv
hdl/sbus_frame_receiver_decoder.sv
hdl/sfrd_checker.sv
test/tb.sv
